[hw/rtl/cubic_bspline_evaluator_top_macros.svh]
// assertion macros for the cubic b-spline evaluator
`ifndef CUBIC_BSPLINE_EVALUATOR_TOP_MACROS_SVH
`define CUBIC_BSPLINE_EVALUATOR_TOP_MACROS_SVH

// same-cycle implication
`define CBS_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("cbs assertion failed");

// next-cycle implication
`define CBS_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("cbs assertion failed");

`endif

[hw/rtl/cbs_pkg.sv]
// shared constants and basis table for the cubic b-spline evaluator
package cbs_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [1:0] CMD_WR_TIME = 2'd0;
  localparam logic [1:0] CMD_WR_AMP  = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;

  localparam logic [6:0] PC_RESET = 7'd4;
  localparam logic [6:0] PC_MIN   = 7'd4;

  // polynomial coefficient width and post-shift width
  localparam int CW   = 40;
  localparam int XW   = CW + 3;
  localparam int LO_W = 20;

  localparam logic [2:0] SEL_M1  = 3'd0;
  localparam logic [2:0] SEL_M2  = 3'd1;
  localparam logic [2:0] SEL_STD = 3'd2;
  localparam logic [2:0] SEL_M4  = 3'd3;
  localparam logic [2:0] SEL_M5  = 3'd4;

  // basis matrices scaled by 12
  localparam logic signed [7:0] BASIS12 [5][4][4] = '{
    '{'{-8'sd12, 8'sd21, -8'sd11, 8'sd2}, '{8'sd36, -8'sd54, 8'sd18, 8'sd0},
      '{-8'sd36, 8'sd36, 8'sd0, 8'sd0}, '{8'sd12, 8'sd0, 8'sd0, 8'sd0}},
    '{'{-8'sd3, 8'sd7, -8'sd6, 8'sd2}, '{8'sd9, -8'sd15, 8'sd6, 8'sd0},
      '{-8'sd9, 8'sd3, 8'sd6, 8'sd0}, '{8'sd3, 8'sd7, 8'sd2, 8'sd0}},
    '{'{-8'sd2, 8'sd6, -8'sd6, 8'sd2}, '{8'sd6, -8'sd12, 8'sd6, 8'sd0},
      '{-8'sd6, 8'sd0, 8'sd6, 8'sd0}, '{8'sd2, 8'sd8, 8'sd2, 8'sd0}},
    '{'{-8'sd2, 8'sd6, -8'sd7, 8'sd3}, '{8'sd6, -8'sd12, 8'sd6, 8'sd0},
      '{-8'sd6, 8'sd0, 8'sd6, 8'sd0}, '{8'sd2, 8'sd8, 8'sd2, 8'sd0}},
    '{'{-8'sd2, 8'sd11, -8'sd21, 8'sd12}, '{8'sd6, -8'sd15, 8'sd9, 8'sd0},
      '{-8'sd6, -8'sd3, 8'sd9, 8'sd0}, '{8'sd2, 8'sd7, 8'sd3, 8'sd0}}
  };

endpackage

[hw/rtl/cbs_frac_div.sv]
// restoring divider for the segment fraction u = (dt << frac) / span
module cbs_frac_div #(
  parameter int FRAC_BITS = cbs_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [32:0]          dt,
  input  logic [32:0]          span,
  output logic                 done,
  output logic [FRAC_BITS:0]   quo
);
  import cbs_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [32:0]      rem;
  logic [32:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [33:0]      r2;

  assign r2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        dvs <= span;
        cnt <= CNT_W'(FRAC_BITS);
        if (span == '0) begin
          quo  <= '0;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          quo <= (FRAC_BITS + 1)'(dt == span);
          rem <= (dt == span) ? '0 : dt;
        end
      end else if (run) begin
        if (r2 >= {1'b0, dvs}) begin
          rem <= 33'(r2 - {1'b0, dvs});
          quo <= {quo[FRAC_BITS-1:0], 1'b1};
        end else begin
          rem <= r2[32:0];
          quo <= {quo[FRAC_BITS-1:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/cubic_bspline_evaluator_top.sv]
// cubic b-spline evaluator top level: tables, segment scan and evaluation sequencer
// write commands are written when accepted; busy stays low
// a query runs a segment scan of one time-table read
// per cycle, a bit-serial fraction divide, four amplitude reads, eight partial
// products and a four-step reciprocal multiply for the divide by twelve
// a query that matches no segment returns with found low
// results are one-cycle done strobes; synchronous reset sets point_count to 4, tables unset
module cubic_bspline_evaluator_top #(
  parameter int MAX_POINTS = cbs_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = cbs_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [6:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] query_time,
  output logic               done,
  output logic signed [31:0] curve_value,
  output logic               found,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cbs_pkg::*;

  localparam int AW_T  = $clog2(MAX_POINTS);
  localparam int AW_A  = $clog2(MAX_POINTS + 2);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int UW    = FRAC_BITS + 1;
  localparam int ACC_W = CW + FRAC_BITS + 3;
  localparam int PW    = LO_W + 1 + UW + 1;
  localparam logic signed [XW-1:0] DIV_BIAS = XW'(64'sd25769803776);
  // ceil(2^35 / 3)
  localparam logic [33:0] RECIP3 = 34'd11453246123;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_DIVU  = 9'b000000100,
    S_AMP   = 9'b000001000,
    S_U2    = 9'b000010000,
    S_U3    = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_NORM  = 9'b010000000,
    S_DIV12 = 9'b100000000
  } state_t;

  state_t state;

  logic [6:0] point_count;
  logic       cfg_wr;

  logic signed [31:0] times_mem [MAX_POINTS];
  logic signed [31:0] amps_mem  [MAX_POINTS + 2];
  logic signed [31:0] t_rdata;
  logic signed [31:0] a_rdata;
  logic               t_re;
  logic               a_re;
  logic [AW_A-1:0]    a_raddr;
  logic               acc_in;

  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      n_q;
  logic [NW-1:0]      ra;
  logic [NW-1:0]      ri;
  logic               rv;
  logic [NW-1:0]      k;
  logic signed [31:0] qt;
  logic signed [31:0] prev;
  logic [2:0]         sel;

  logic [32:0]        dt_r;
  logic [32:0]        span_r;
  logic               div_go;
  logic               div_done;
  logic [UW-1:0]      div_quo;

  logic [UW-1:0]      u;
  logic [UW-1:0]      u2;
  logic [UW-1:0]      u3;
  logic [2:0]         aj;
  logic [1:0]         aj_d;
  logic               av;
  logic signed [CW-1:0] c [4];

  logic [3:0]         ms;
  logic signed [PW-1:0] prod;
  logic               mv;
  logic               mh;
  logic signed [LO_W:0] ma;
  logic signed [UW:0]   mb;
  logic [UW-1:0]      uv;
  logic signed [ACC_W-1:0] acc;

  logic signed [XW-1:0] xs;
  logic [35:0]        y;
  logic [16:0]        rx;
  logic [16:0]        rm;
  logic [33:0]        rprod;
  logic [67:0]        rterm;
  logic [67:0]        racc;
  logic [2:0]         dcnt;

  assign acc_in = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, point_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      point_count <= pwdata[6:0];
    end
  end

  always_comb begin
    if (point_count < PC_MIN) begin
      n_eff = NW'(4);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
  end

  always_comb begin
    if (k > NW'(1) && 32'(k) + 32'd3 < 32'(n_q)) begin
      sel = SEL_STD;
    end else begin
      sel = SEL_STD;
      if (k == NW'(0)) sel = SEL_M1;
      if (k == NW'(1)) sel = SEL_M2;
      if (32'(k) + 32'd3 == 32'(n_q)) sel = SEL_M4;
      if (32'(k) + 32'd2 == 32'(n_q)) sel = SEL_M5;
    end
  end

  assign t_re    = (state == S_SCAN) && (ra < n_q);
  assign a_re    = (state == S_AMP) && (aj < 3'd4);
  assign a_raddr = AW_A'(32'(k) + 32'(aj));

  always_ff @(posedge clk) begin
    if (acc_in && command == CMD_WR_TIME && 32'(entry_index) < 32'(MAX_POINTS)) begin
      times_mem[AW_T'(entry_index)] <= entry_value;
    end
    if (t_re) begin
      t_rdata <= times_mem[AW_T'(ra)];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && command == CMD_WR_AMP && 32'(entry_index) < 32'(MAX_POINTS + 2)) begin
      amps_mem[AW_A'(entry_index)] <= entry_value;
    end
    if (a_re) begin
      a_rdata <= amps_mem[a_raddr];
    end
  end

  cbs_frac_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .dt  (dt_r),
    .span(span_r),
    .done(div_done),
    .quo (div_quo)
  );

  always_comb begin
    case (ms[2:1])
      2'd0:    uv = u3;
      2'd1:    uv = u2;
      2'd2:    uv = u;
      default: uv = UW'(1) << FRAC_BITS;
    endcase
    if (ms[0]) begin
      ma = (LO_W + 1)'($signed(c[ms[2:1]][CW-1:LO_W]));
    end else begin
      ma = {1'b0, c[ms[2:1]][LO_W-1:0]};
    end
    mb = {1'b0, uv};
  end

  // partial products of (y >> 2) * RECIP3 in 17-bit halves
  always_comb begin
    rx    = dcnt[0] ? y[35:19] : y[18:2];
    rm    = dcnt[1] ? RECIP3[33:17] : RECIP3[16:0];
    rprod = 34'(rx) * 34'(rm);
    case (dcnt[1:0])
      2'd0:    rterm = 68'(rprod);
      2'd3:    rterm = {rprod, 34'd0};
      default: rterm = {17'd0, rprod, 17'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
      rv     <= 1'b0;
      av     <= 1'b0;
      mv     <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc_in && command == CMD_EVAL) begin
            qt    <= query_time;
            n_q   <= n_eff;
            ra    <= '0;
            rv    <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rv <= t_re;
          ri <= ra;
          if (t_re) ra <= ra + 1'b1;
          if (rv) begin
            prev <= t_rdata;
            if (ri != '0 && qt >= prev && qt <= t_rdata) begin
              k      <= ri - 1'b1;
              dt_r   <= 33'({qt[31], qt} - {prev[31], prev});
              span_r <= 33'({t_rdata[31], t_rdata} - {prev[31], prev});
              div_go <= 1'b1;
              state  <= S_DIVU;
            end else if (ri == n_q - 1'b1) begin
              done        <= 1'b1;
              found       <= 1'b0;
              curve_value <= '0;
              state       <= S_IDLE;
            end
          end
        end
        S_DIVU: begin
          if (div_done) begin
            u     <= div_quo;
            aj    <= '0;
            av    <= 1'b0;
            c[0]  <= '0;
            c[1]  <= '0;
            c[2]  <= '0;
            c[3]  <= '0;
            state <= S_AMP;
          end
        end
        S_AMP: begin
          av   <= a_re;
          aj_d <= aj[1:0];
          if (a_re) aj <= aj + 1'b1;
          if (av) begin
            for (int i = 0; i < 4; i++) begin
              c[i] <= c[i] + (CW'(BASIS12[sel][i][aj_d]) * CW'(a_rdata));
            end
            if (aj_d == 2'd3) state <= S_U2;
          end
        end
        S_U2: begin
          u2    <= UW'((2 * UW)'(u) * (2 * UW)'(u) >> FRAC_BITS);
          state <= S_U3;
        end
        S_U3: begin
          u3    <= UW'((2 * UW)'(u2) * (2 * UW)'(u) >> FRAC_BITS);
          ms    <= '0;
          mv    <= 1'b0;
          acc   <= ACC_W'(6) <<< FRAC_BITS;
          state <= S_MUL;
        end
        S_MUL: begin
          if (ms < 4'd8) begin
            prod <= PW'(ma) * PW'(mb);
            mh   <= ms[0];
            mv   <= 1'b1;
            ms   <= ms + 1'b1;
          end else begin
            mv <= 1'b0;
          end
          if (mv) begin
            if (mh) begin
              acc <= acc + (ACC_W'(prod) <<< LO_W);
            end else begin
              acc <= acc + ACC_W'(prod);
            end
            if (ms == 4'd8) state <= S_NORM;
          end
        end
        S_NORM: begin
          if (xs < -DIV_BIAS) begin
            y <= '0;
          end else if (xs > DIV_BIAS - XW'(1)) begin
            y <= 36'(DIV_BIAS + DIV_BIAS - XW'(1));
          end else begin
            y <= 36'(xs + DIV_BIAS);
          end
          racc  <= '0;
          dcnt  <= '0;
          state <= S_DIV12;
        end
        S_DIV12: begin
          if (dcnt == 3'd4) begin
            curve_value <= {~racc[66], racc[65:35]};
            found       <= 1'b1;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            racc <= racc + rterm;
            dcnt <= dcnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign xs = XW'(acc >>> FRAC_BITS);

`include "cubic_bspline_evaluator_top_macros.svh"

  `CBS_ASSERT_NEXT(a_done_pulse, done, !done)
  `CBS_ASSERT_NOW(a_miss_zero, done && !found, curve_value == 32'sd0)
  `CBS_ASSERT_NEXT(a_eval_busy, start && !busy && command == CMD_EVAL, busy)
  `CBS_ASSERT_NOW(a_done_idle, done, !busy)

endmodule
